/* src/mcbf_pkg.sv */
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types and sizes for the multi-channel byte fifo: operation and
// status codes, channel count, ring depth and the derived widths.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  // channel set and ring size
  localparam int NUM_CHANNELS  = 8;
  localparam int CHANNEL_DEPTH = 64;

  // derived widths
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W  = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(CHANNEL_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_CHANNELS * CHANNEL_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // field widths of the beats
  localparam int OP_W   = 3;
  localparam int CHF_W  = 3;
  localparam int DATA_W = 8;
  localparam int STAT_W = 3;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_CLOSE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_BAD    = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOFREE = 3'd4
  } status_t;

endpackage

/* src/multi_channel_byte_fifo_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_top
// A set of byte fifo channels kept as ring buffers in one shared byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat (in_op, in_channel, in_data_in, in_final_byte) is one
//   operation: create opens the lowest closed channel, write appends a byte,
//   read removes the oldest byte, close frees a channel, clear empties it.
//   Every input beat gives exactly one output beat with a status, the
//   channel, the byte read (zero unless a read succeeded) and an echo of
//   in_final_byte. Both channels use valid/stall; a beat moves at an edge
//   with valid high and stall low.
//   The channel table and the store update at the accepting edge; the
//   result then passes through the middle stage into the output register.
//   Throughput is one beat per cycle while out_stall is low, with one update
//   of the per-channel pointer table and one store write or read per beat.
//   While out_stall is high the result is held; one more beat is taken into
//   the middle stage, then in_stall rises until the output drains.
//   After reset all channels are closed with empty pointers; the byte store
//   is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcbf_pkg::OP_W-1:0]     in_op,
  input  logic [mcbf_pkg::CHF_W-1:0]    in_channel,
  input  logic [mcbf_pkg::DATA_W-1:0]   in_data_in,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcbf_pkg::STAT_W-1:0]   out_status,
  output logic [mcbf_pkg::CHF_W-1:0]    out_channel_out,
  output logic [mcbf_pkg::DATA_W-1:0]   out_data_out,
  output logic                          out_final_echo
);

  localparam int NCH   = mcbf_pkg::NUM_CHANNELS;
  localparam int DEPTH = mcbf_pkg::CHANNEL_DEPTH;
  localparam int CH_W  = mcbf_pkg::CH_W;
  localparam int PTR_W = mcbf_pkg::PTR_W;
  localparam int CNT_W = mcbf_pkg::CNT_W;
  localparam int ADDR_W = mcbf_pkg::ADDR_W;

  // channel table
  logic [NCH-1:0]   open_r, open_nxt;
  logic [PTR_W-1:0] rptr_r [NCH];
  logic [PTR_W-1:0] rptr_nxt [NCH];
  logic [PTR_W-1:0] wptr_r [NCH];
  logic [PTR_W-1:0] wptr_nxt [NCH];
  logic [CNT_W-1:0] fill_r [NCH];
  logic [CNT_W-1:0] fill_nxt [NCH];

  // middle stage
  logic                        s1_valid_r;
  mcbf_pkg::status_t           s1_status_r;
  logic [mcbf_pkg::CHF_W-1:0]  s1_chan_r;
  logic                        s1_rd_r;
  logic                        s1_fin_r;

  // output register
  logic                        out_valid_r;
  mcbf_pkg::status_t           out_status_r;
  logic [mcbf_pkg::CHF_W-1:0]  out_chan_r;
  logic [mcbf_pkg::DATA_W-1:0] out_data_r;
  logic                        out_fin_r;

  // handshake
  logic accept;
  logic out_adv;
  logic s1_move;

  // operation decode
  logic                        ch_ok;
  logic [CH_W-1:0]             ch_idx;
  logic                        free_found;
  logic [CH_W-1:0]             free_idx;
  mcbf_pkg::status_t           status_nxt;
  logic [mcbf_pkg::CHF_W-1:0]  chan_nxt;
  logic                        wr_go;
  logic                        rd_go;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ADDR_W-1:0]           rd_addr;
  logic [mcbf_pkg::DATA_W-1:0] ram_rdata;

  // flow control
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign accept   = in_valid && !in_stall;

  // channel selection
  assign ch_idx = CH_W'(in_channel);
  assign ch_ok  = (32'(in_channel) < NCH) && open_r[ch_idx];

  // lowest closed channel
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  // store addresses
  assign wr_addr = ADDR_W'(ch_idx) * ADDR_W'(DEPTH) + ADDR_W'(wptr_r[ch_idx]);
  assign rd_addr = ADDR_W'(ch_idx) * ADDR_W'(DEPTH) + ADDR_W'(rptr_r[ch_idx]);

  // operation decode and table update
  always_comb begin
    open_nxt   = open_r;
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    fill_nxt   = fill_r;
    status_nxt = mcbf_pkg::ST_OK;
    chan_nxt   = in_channel;
    wr_go      = 1'b0;
    rd_go      = 1'b0;
    unique case (mcbf_pkg::op_t'(in_op))
      mcbf_pkg::OP_CREATE: begin
        chan_nxt = '0;
        if (free_found) begin
          open_nxt[free_idx] = 1'b1;
          rptr_nxt[free_idx] = '0;
          wptr_nxt[free_idx] = '0;
          fill_nxt[free_idx] = '0;
          chan_nxt = mcbf_pkg::CHF_W'(free_idx);
        end else begin
          status_nxt = mcbf_pkg::ST_NOFREE;
        end
      end
      mcbf_pkg::OP_WRITE: begin
        if (!ch_ok) begin
          status_nxt = mcbf_pkg::ST_BAD;
        end else if (fill_r[ch_idx] >= CNT_W'(DEPTH)) begin
          status_nxt = mcbf_pkg::ST_FULL;
        end else begin
          wr_go = 1'b1;
          wptr_nxt[ch_idx] = (wptr_r[ch_idx] == PTR_W'(DEPTH - 1)) ? '0 :
                             wptr_r[ch_idx] + 1'b1;
          fill_nxt[ch_idx] = fill_r[ch_idx] + 1'b1;
        end
      end
      mcbf_pkg::OP_READ: begin
        if (!ch_ok) begin
          status_nxt = mcbf_pkg::ST_BAD;
        end else if (fill_r[ch_idx] == '0) begin
          status_nxt = mcbf_pkg::ST_EMPTY;
        end else begin
          rd_go = 1'b1;
          rptr_nxt[ch_idx] = (rptr_r[ch_idx] == PTR_W'(DEPTH - 1)) ? '0 :
                             rptr_r[ch_idx] + 1'b1;
          fill_nxt[ch_idx] = fill_r[ch_idx] - 1'b1;
        end
      end
      mcbf_pkg::OP_CLOSE: begin
        if (!ch_ok) begin
          status_nxt = mcbf_pkg::ST_BAD;
        end else begin
          open_nxt[ch_idx] = 1'b0;
          rptr_nxt[ch_idx] = '0;
          wptr_nxt[ch_idx] = '0;
          fill_nxt[ch_idx] = '0;
        end
      end
      mcbf_pkg::OP_CLEAR: begin
        if (!ch_ok) begin
          status_nxt = mcbf_pkg::ST_BAD;
        end else begin
          rptr_nxt[ch_idx] = '0;
          wptr_nxt[ch_idx] = '0;
          fill_nxt[ch_idx] = '0;
        end
      end
      default: begin
        status_nxt = mcbf_pkg::ST_BAD;
      end
    endcase
  end

  // channel table registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        rptr_r[i] <= '0;
        wptr_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (accept) begin
      open_r <= open_nxt;
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // shared byte store
  mcbf_ram #(
    .WIDTH (mcbf_pkg::DATA_W),
    .DEPTH (mcbf_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_go),
    .wr_addr (wr_addr),
    .wr_data (in_data_in),
    .rd_en   (accept && rd_go),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // middle stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // middle stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_nxt;
      s1_chan_r   <= chan_nxt;
      s1_rd_r     <= rd_go;
      s1_fin_r    <= in_final_byte;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // output payload, read byte taken from the store port
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_chan_r   <= s1_chan_r;
      out_data_r   <= s1_rd_r ? ram_rdata : '0;
      out_fin_r    <= s1_fin_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_channel_out = out_chan_r;
  assign out_data_out    = out_data_r;
  assign out_final_echo  = out_fin_r;

  // checks
  a_data_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r != '0) |-> out_status_r == mcbf_pkg::ST_OK)
    else $error("read byte with non-ok status");

  a_nofree_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == mcbf_pkg::ST_NOFREE) |-> out_chan_r == '0)
    else $error("no free channel reported with nonzero channel");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[ch_idx] <= CNT_W'(DEPTH))
    else $error("channel fill count beyond ring depth");

  a_create_opens: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == mcbf_pkg::OP_CREATE) && free_found |=> open_r[$past(free_idx)])
    else $error("created channel not marked open");

endmodule

/* src/mcbf_ram.sv */
// ----------------------------------------------------------------------------
// mcbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
